// ===== design/signed_int_to_decimal_ascii_unit_defines.svh =====
// Assertion macros shared by the signed integer to decimal text design.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SITDA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, when it holds, implies another one on the next edge.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// A condition that, when it holds, implies another one on the same edge.
`define SITDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/sitda_pkg.sv =====
// Package for the signed integer to decimal text unit: word type, constants
// and the BCD correction function. Depends on nothing.
`timescale 1ns / 1ps

package sitda_pkg;

  // Decimal digits of the largest magnitude, 2^31.
  localparam int DIGITS = 10;
  localparam int BCD_W = 4 * DIGITS;
  localparam int MAG_W = 32;
  // Binary bits folded into the BCD register per conversion cycle.
  localparam int BITS_PER_CYCLE = 4;
  localparam int CONV_CYCLES = MAG_W / BITS_PER_CYCLE;
  localparam int CNT_W = $clog2(CONV_CYCLES);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_CYCLES - 1);
  localparam int IDX_W = $clog2(DIGITS);

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO = 6'd48;

  // One queued word: sign and unsigned magnitude.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } sitda_item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic        valid;
    sitda_item_t item;
  } sitda_head_t;

  // Adds three to every BCD digit of five or more, ahead of a left shift.
  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (res[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = res[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // Index of the most significant non-zero digit, zero when all are zero.
  function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/sitda_front.sv =====
// Front end: takes the input word and splits it into sign and magnitude.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_front (
  input  logic [31:0]           value,
  input  logic                  value_valid,
  output logic                  value_stall,
  input  logic                  full,
  output logic                  push,
  output sitda_pkg::sitda_item_t push_item
);

  // The word is taken whenever the queue has room.
  assign value_stall = full;
  assign push = value_valid && !full;

  // Magnitude in unsigned arithmetic, so the most negative value stays exact.
  assign push_item.neg = value[31];
  assign push_item.mag = value[31] ? (32'd0 - value) : value;

endmodule

// ===== design/sitda_queue.sv =====
// Two-entry queue between the front end and the conversion back end.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sitda_pkg::sitda_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output sitda_pkg::sitda_head_t head
);

  sitda_pkg::sitda_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign full = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.item = slots[rd_ptr];

endmodule

// ===== design/sitda_back.sv =====
// Back end: binary to BCD conversion, four bits a cycle, then the character
// emitter with its output register. Depends on sitda_pkg and the defines header.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_unit_defines.svh"

module sitda_back (
  input  logic                   clk,
  input  logic                   rst,
  input  sitda_pkg::sitda_head_t head,
  output logic                   pop,
  output logic [5:0]             char_code,
  output logic                   last_char,
  output logic                   char_valid,
  input  logic                   char_stall
);

  // Converter registers.
  logic                              conv_busy;
  logic                              conv_done;
  logic [sitda_pkg::CNT_W-1:0]       conv_cnt;
  logic                              conv_neg;
  logic [sitda_pkg::MAG_W-1:0]       conv_mag;
  logic [sitda_pkg::BCD_W-1:0]       conv_bcd;
  logic [sitda_pkg::MAG_W-1:0]       mag_next;
  logic [sitda_pkg::BCD_W-1:0]       bcd_next;

  // Emitter registers.
  logic                              emit_busy;
  logic                              emit_minus;
  logic [sitda_pkg::IDX_W-1:0]       emit_idx;
  logic [sitda_pkg::BCD_W-1:0]       emit_bcd;
  logic [3:0]                        emit_digit;

  logic out_free;
  logic emit_fire;
  logic emit_finish;
  logic handoff;

  // Handshake between the converter, the emitter and the output register.
  assign out_free    = !char_valid || !char_stall;
  assign emit_fire   = emit_busy && out_free;
  assign emit_finish = emit_fire && !emit_minus && (emit_idx == '0);
  assign handoff     = conv_done && (!emit_busy || emit_finish);
  assign pop         = head.valid && !conv_busy && (!conv_done || handoff);

  // Four shift-and-correct steps of the double dabble per cycle.
  always_comb begin
    logic [sitda_pkg::BCD_W-1:0] b;
    logic [sitda_pkg::MAG_W-1:0] m;
    b = conv_bcd;
    m = conv_mag;
    for (int s = 0; s < sitda_pkg::BITS_PER_CYCLE; s++) begin
      b = sitda_pkg::dabble_adjust(b);
      {b, m} = {b[sitda_pkg::BCD_W-2:0], m, 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  // Converter control.
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_busy <= 1'b0;
      conv_done <= 1'b0;
      conv_cnt  <= '0;
    end else if (pop) begin
      conv_busy <= 1'b1;
      conv_done <= 1'b0;
      conv_cnt  <= '0;
    end else if (conv_busy) begin
      conv_cnt <= conv_cnt + 1'b1;
      if (conv_cnt == sitda_pkg::CONV_LAST) begin
        conv_busy <= 1'b0;
        conv_done <= 1'b1;
      end
    end else if (handoff) begin
      conv_done <= 1'b0;
    end
  end

  // Converter data path.
  always_ff @(posedge clk) begin
    if (pop) begin
      conv_neg <= head.item.neg;
      conv_mag <= head.item.mag;
      conv_bcd <= '0;
    end else if (conv_busy) begin
      conv_mag <= mag_next;
      conv_bcd <= bcd_next;
    end
  end

  // Emitter control: minus sign first, then digits from the top one down.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy  <= 1'b0;
      emit_minus <= 1'b0;
      emit_idx   <= '0;
    end else if (handoff) begin
      emit_busy  <= 1'b1;
      emit_minus <= conv_neg;
      emit_idx   <= sitda_pkg::top_digit(conv_bcd);
    end else if (emit_finish) begin
      emit_busy <= 1'b0;
    end else if (emit_fire) begin
      if (emit_minus) begin
        emit_minus <= 1'b0;
      end else begin
        emit_idx <= emit_idx - 1'b1;
      end
    end
  end

  // Emitter digit store.
  always_ff @(posedge clk) begin
    if (handoff) begin
      emit_bcd <= conv_bcd;
    end
  end

  assign emit_digit = emit_bcd[{emit_idx, 2'b00} +: 4];

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_free) begin
      char_valid <= emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      char_code <= emit_minus ? sitda_pkg::CHAR_MINUS
                              : sitda_pkg::CHAR_ZERO + {2'b00, emit_digit};
      last_char <= !emit_minus && (emit_idx == '0);
    end
  end

  // A converted word is never waiting while the next one is being converted.
  `SITDA_ASSERT_ALWAYS(a_conv_exclusive, !(conv_busy && conv_done), "converter busy and done")
  // The final conversion step always leaves a result waiting.
  `SITDA_ASSERT_NEXT(a_conv_finish, conv_busy && !pop && (conv_cnt == sitda_pkg::CONV_LAST), conv_done, "conversion did not finish")
  // The digit pointer stays within the BCD register.
  `SITDA_ASSERT_SAME(a_idx_range, emit_busy, emit_idx < sitda_pkg::IDX_W'(sitda_pkg::DIGITS), "digit index out of range")
  // A minus sign is never the final character of a word.
  `SITDA_ASSERT_SAME(a_minus_not_last, char_valid && (char_code == sitda_pkg::CHAR_MINUS), !last_char, "minus sign marked last")

endmodule

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per output word.
// An accepted word passes the queue, the BCD conversion loop, the emitter and the output
// register; the BCD conversion of the next number overlaps the emission of the last one,
// one character per cycle while char_stall is low.
// Reset (synchronous, active high) empties the queue, the converter and the output.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] value,
  input  logic        value_valid,
  output logic        value_stall,
  output logic [5:0]  char_code,
  output logic        last_char,
  output logic        char_valid,
  input  logic        char_stall
);

  logic                   full;
  logic                   push;
  logic                   pop;
  sitda_pkg::sitda_item_t push_item;
  sitda_pkg::sitda_head_t head;

  // Sign and magnitude split at the input.
  sitda_front u_front (
    .value       (value),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .full        (full),
    .push        (push),
    .push_item   (push_item)
  );

  // Decoupling queue.
  sitda_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

  // Conversion and character output.
  sitda_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_valid (char_valid),
    .char_stall (char_stall)
  );

endmodule

// ===== bench/tb_signed_int_to_decimal_ascii_unit.sv =====
// Self-checking testbench for signed_int_to_decimal_ascii_unit: drives signed
// words in, predicts their decimal text and checks every character that comes out.
// Depends on sitda_pkg for the character constants and on the unit itself.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_TAIL = 30;

  // One expected character, tagged with the word that produced it.
  typedef struct {
    logic [31:0] src;
    logic [5:0]  code;
    logic        last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [31:0] value = '0;
  logic        value_valid = 1'b0;
  logic        value_stall;
  logic [5:0]  char_code;
  logic        last_char;
  logic        char_valid;
  logic        char_stall = 1'b0;

  text_char_t pending_chars[$];
  int         failures = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;

  signed_int_to_decimal_ascii_unit dut (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .char_code  (char_code),
    .last_char  (last_char),
    .char_valid (char_valid),
    .char_stall (char_stall)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Works out the decimal text of a word and queues it, sign first.
  function automatic void spell_decimal(input logic [31:0] word);
    logic [31:0] mag;
    logic [3:0]  digit_buf [10];
    int          ndig;
    text_char_t  c;
    mag = word[31] ? (32'd0 - word) : word;
    ndig = 0;
    do begin
      digit_buf[ndig] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      ndig++;
    end while (mag != 0);
    c.src = word;
    if (word[31]) begin
      c.code = sitda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      c.code = sitda_pkg::CHAR_ZERO + 6'(digit_buf[k]);
      c.last = (k == 0);
      pending_chars.push_back(c);
    end
  endfunction

  // A random word: mostly one whose magnitude has a random number of digits, either sign, else any 32-bit value.
  function automatic logic [31:0] rand_word();
    int unsigned ndig;
    longint      lo;
    longint      hi;
    logic [31:0] mag;
    bit          neg;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    ndig = $urandom_range(1, 10);
    neg = 1'($urandom_range(0, 1));
    lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
    hi = 64'd10 ** ndig - 1;
    if (ndig == 10) begin
      hi = neg ? 64'd2147483648 : 64'd2147483647;
    end
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? (32'd0 - mag) : mag;
  endfunction

  function automatic void log_failure(input string msg);
    if (failures < 10) begin
      $display("[%0t] %s", $realtime, msg);
    end
    failures++;
  endfunction

  // Sends one word after a random gap and queues its text once it is taken.
  task automatic send_word(input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      value_valid <= 1'b0;
      value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    value <= word;
    value_valid <= 1'b1;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    spell_decimal(word);
  endtask

  // Lowers valid and waits until every expected character has arrived.
  task automatic wait_drained();
    value_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // Zero, digit-count boundaries of both signs, the largest and most negative values and bit patterns.
  task automatic test_edge_values();
    logic [31:0] edge_vals [] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd12345, -32'sd54321, 32'd999999999, -32'sd999999999, 32'd1000000000,
      -32'sd1000000000, 32'h7FFFFFFF, 32'h80000001, 32'h80000000,
      32'h55555555, 32'hAAAAAAAA, 32'd1234567890, 32'hFFFFFFF6
    };
    foreach (edge_vals[i]) begin
      send_word(edge_vals[i]);
    end
  endtask

  // Back-to-back words: no gaps from the sender and no new receiver stalls.
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (15) send_word(rand_word());
    quiet = 1'b0;
  endtask

  // Sender holds off until the unit has emptied, then resumes.
  task automatic test_drain_pause();
    repeat (8) send_word(rand_word());
    wait_drained();
    repeat (8) send_word(rand_word());
    wait_drained();
  endtask

  task automatic test_random_values();
    repeat (67) send_word(rand_word());
  endtask

  // Receiver stalls: bursts of random length drawn from the gap picker.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      char_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      char_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  // Each accepted character is compared with the oldest expected one.
  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst && char_valid && !char_stall) begin
      if (pending_chars.size() == 0) begin
        log_failure($sformatf("unexpected character: code %0d last %0d",
                              char_code, last_char));
      end else begin
        exp_c = pending_chars.pop_front();
        if (char_code !== exp_c.code || last_char !== exp_c.last) begin
          log_failure($sformatf(
            "word %0d: expected code %0d last %0d, got code %0d last %0d",
            $signed(exp_c.src), exp_c.code, exp_c.last, char_code, last_char));
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (value_valid && !value_stall) || (char_valid && !char_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_values();
    test_back_to_back();
    test_drain_pause();
    test_random_values();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (pending_chars.size() != 0) begin
      log_failure($sformatf("%0d characters never arrived", pending_chars.size()));
    end
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii_unit.f =====
+incdir+design
design/sitda_pkg.sv
design/sitda_front.sv
design/sitda_queue.sv
design/sitda_back.sv
design/signed_int_to_decimal_ascii_unit.sv
bench/tb_signed_int_to_decimal_ascii_unit.sv
